@@ rtl/sobet_pkg.sv @@
// ----------------------------------------------------------------------------
// sobet_pkg
// Shared widths, register map and constants of the Sobel edge threshold unit.
// ----------------------------------------------------------------------------
package sobet_pkg;

   // Word field widths
   localparam int GRAY_W      = 8;
   localparam int CHAN_W      = 8;
   localparam int EDGE_ROW_W  = 12;
   localparam int EDGE_COL_W  = 10;

   // Register widths
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int THRESH_REG_W = 11;

   // Register map (index = paddr[3:2])
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

   localparam logic [WIDTH_REG_W-1:0]  IMAGE_WIDTH_RST    = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RST   = 13'd480;
   localparam logic [THRESH_REG_W-1:0] EDGE_THRESHOLD_RST = 11'd70;

   // Size compares run at this width (covers the largest MAX_HEIGHT)
   localparam int SIZE_W   = 17;
   localparam int MIN_SIZE = 3;

   // Divide by 3 on a channel sum: floor(sum * 683 / 2048), exact for sum <= 765
   localparam int SUM_W        = 10;
   localparam int RECIP_W      = 20;
   localparam int RECIP_3      = 683;
   localparam int RECIP_SHIFT  = 11;

   // Gradient magnitudes
   localparam int GRAD_W   = 10;  // |gx|, |gy| <= 1020
   localparam int SQ_W     = 20;
   localparam int LIM_W    = 12;
   localparam int LIM_SQ_W = 24;

endpackage

@@ rtl/sobet_if.sv @@
// ----------------------------------------------------------------------------
// sobet_if
// Valid/ready channels of the Sobel edge threshold unit: pixel in, result out.
// ----------------------------------------------------------------------------
interface sobet_pix_if;
   logic                           valid;
   logic                           ready;
   logic [sobet_pkg::CHAN_W-1:0]   red;
   logic [sobet_pkg::CHAN_W-1:0]   green;
   logic [sobet_pkg::CHAN_W-1:0]   blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface sobet_res_if;
   logic                              valid;
   logic                              ready;
   logic [sobet_pkg::GRAY_W-1:0]      gray;
   logic                              edge_valid;
   logic                              edge_res;
   logic [sobet_pkg::EDGE_ROW_W-1:0]  edge_row;
   logic [sobet_pkg::EDGE_COL_W-1:0]  edge_col;

   modport source (output valid, output gray, output edge_valid, output edge_res,
                   output edge_row, output edge_col, input ready);
   modport sink   (input valid, input gray, input edge_valid, input edge_res,
                   input edge_row, input edge_col, output ready);
endinterface

@@ rtl/sobet_ram.sv @@
// ----------------------------------------------------------------------------
// sobet_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sobet_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/sobel_edge_threshold_unit.sv @@
// ----------------------------------------------------------------------------
// sobel_edge_threshold_unit
// Streaming RGB to gray conversion with a 3x3 Sobel edge flag per pixel.
//
// Takes one RGB pixel per clock, unless the output stalls, in row-major order
// and returns one word per pixel: its gray value (r+g+b)/3 and the edge flag
// of the pixel one row up and one column left, set when the squared Sobel
// magnitude is at least (edge_threshold+1)^2 (compared exactly on squares).
// Sustained rate is one pixel per clock unless the output stalls. The rate is
// set by the line RAM, which holds the two previous gray rows packed in one
// word per column: each pixel does one read at accept and one write-back from
// stage 1 to a different column, so reads and writes never collide. image_width
// and image_height are clamped to [3, MAX_WIDTH] and [3, MAX_HEIGHT]; the user
// must see that registers are written only while the unit is idle; the unit
// does not enforce it. The line RAM is not cleared.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   sobet_pix_if.sink                        req_chan,
   sobet_res_if.source                      rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sobet_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sobet_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sobet_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int SIZE_W     = sobet_pkg::SIZE_W;
   localparam int GRAY_W     = sobet_pkg::GRAY_W;
   localparam int SUM_W      = sobet_pkg::SUM_W;
   localparam int RECIP_W    = sobet_pkg::RECIP_W;
   localparam int GRAD_W     = sobet_pkg::GRAD_W;
   localparam int SQ_W       = sobet_pkg::SQ_W;
   localparam int LIM_W      = sobet_pkg::LIM_W;
   localparam int LIM_SQ_W   = sobet_pkg::LIM_SQ_W;
   localparam int EDGE_ROW_W = sobet_pkg::EDGE_ROW_W;
   localparam int EDGE_COL_W = sobet_pkg::EDGE_COL_W;
   localparam int CSR_DATA_W = sobet_pkg::CSR_DATA_W;
   localparam int ACC_W      = GRAD_W + 3;  // weighted sum of three pixels

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [sobet_pkg::WIDTH_REG_W-1:0]  image_width_ff;
   logic [sobet_pkg::HEIGHT_REG_W-1:0] image_height_ff;
   logic [sobet_pkg::THRESH_REG_W-1:0] edge_threshold_ff;
   logic                               csr_wr;
   logic [1:0]                         csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= sobet_pkg::IMAGE_WIDTH_RST;
         image_height_ff   <= sobet_pkg::IMAGE_HEIGHT_RST;
         edge_threshold_ff <= sobet_pkg::EDGE_THRESHOLD_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            sobet_pkg::REG_IMAGE_WIDTH: begin
               image_width_ff <= csr_pwdata[sobet_pkg::WIDTH_REG_W-1:0];
            end
            sobet_pkg::REG_IMAGE_HEIGHT: begin
               image_height_ff <= csr_pwdata[sobet_pkg::HEIGHT_REG_W-1:0];
            end
            sobet_pkg::REG_EDGE_THRESHOLD: begin
               edge_threshold_ff <= csr_pwdata[sobet_pkg::THRESH_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         sobet_pkg::REG_IMAGE_WIDTH:    csr_prdata = CSR_DATA_W'(image_width_ff);
         sobet_pkg::REG_IMAGE_HEIGHT:   csr_prdata = CSR_DATA_W'(image_height_ff);
         sobet_pkg::REG_EDGE_THRESHOLD: csr_prdata = CSR_DATA_W'(edge_threshold_ff);
         default:                       csr_prdata = '0;
      endcase
   end

   // (threshold+1)^2, refreshed every clock from the register
   logic [LIM_W-1:0]    lim;
   logic [LIM_SQ_W-1:0] lim_sq_ff;

   assign lim = LIM_W'(edge_threshold_ff) + LIM_W'(1);

   always_ff @(posedge clock) begin
      lim_sq_ff <= LIM_SQ_W'(lim) * LIM_SQ_W'(lim);
   end

   // Clamped frame size
   logic [SIZE_W-1:0] wreg_ext;
   logic [SIZE_W-1:0] hreg_ext;
   logic [SIZE_W-1:0] w_lim;
   logic [SIZE_W-1:0] h_lim;

   assign wreg_ext = SIZE_W'(image_width_ff);
   assign hreg_ext = SIZE_W'(image_height_ff);

   always_comb begin
      if (wreg_ext < SIZE_W'(sobet_pkg::MIN_SIZE)) begin
         w_lim = SIZE_W'(sobet_pkg::MIN_SIZE);
      end else if (wreg_ext > SIZE_W'(MAX_WIDTH)) begin
         w_lim = SIZE_W'(MAX_WIDTH);
      end else begin
         w_lim = wreg_ext;
      end
      if (hreg_ext < SIZE_W'(sobet_pkg::MIN_SIZE)) begin
         h_lim = SIZE_W'(sobet_pkg::MIN_SIZE);
      end else if (hreg_ext > SIZE_W'(MAX_HEIGHT)) begin
         h_lim = SIZE_W'(MAX_HEIGHT);
      end else begin
         h_lim = hreg_ext;
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control: every stage moves when the output word is free
   // ------------------------------------------------------------------
   logic adv;
   logic req_fire;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   assign adv            = !v4_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign req_fire       = req_chan.valid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 0: accept, gray conversion, position counters, line read
   // ------------------------------------------------------------------
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [SIZE_W-1:0]  col_nxt;
   logic [SIZE_W-1:0]  row_nxt;
   logic [SUM_W-1:0]   chan_sum;
   logic [RECIP_W-1:0] gray_prod;
   logic [GRAY_W-1:0]  gray0;

   assign chan_sum  = SUM_W'(req_chan.red) + SUM_W'(req_chan.green)
                    + SUM_W'(req_chan.blue);
   assign gray_prod = RECIP_W'(chan_sum) * RECIP_W'(sobet_pkg::RECIP_3);
   assign gray0     = gray_prod[sobet_pkg::RECIP_SHIFT +: GRAY_W];

   assign col_nxt = SIZE_W'(col_ff) + SIZE_W'(1);
   assign row_nxt = SIZE_W'(row_ff) + SIZE_W'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (col_nxt >= w_lim) begin
         col_in = '0;
         row_in = (row_nxt >= h_lim) ? '0 : row_nxt[ROW_W-1:0];
      end else begin
         col_in = col_nxt[COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_fire) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   logic [GRAY_W-1:0] gray1_ff;
   logic [COL_W-1:0]  col1_ff;
   logic [ROW_W-1:0]  row1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         gray1_ff <= gray0;
         col1_ff  <= col_ff;
         row1_ff  <= row_ff;
      end
   end

   // Line RAM word: upper byte = two rows up, lower byte = one row up
   logic                  ram_we;
   logic [2*GRAY_W-1:0]   ram_wdata;
   logic [2*GRAY_W-1:0]   ram_rdata;
   logic [GRAY_W-1:0]     top;
   logic [GRAY_W-1:0]     mid;

   assign top       = ram_rdata[2*GRAY_W-1:GRAY_W];
   assign mid       = ram_rdata[GRAY_W-1:0];
   assign ram_we    = adv && v1_ff;
   assign ram_wdata = {mid, gray1_ff};

   sobet_ram #(
      .WIDTH (2*GRAY_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (col1_ff),
      .wdata (ram_wdata),
      .re    (req_fire),
      .raddr (col_ff),
      .rdata (ram_rdata)
   );

   // ------------------------------------------------------------------
   // Stage 1: window shift, gradients, edge position
   // ------------------------------------------------------------------
   logic [GRAY_W-1:0] win_ff [0:5];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (ram_we) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= gray1_ff;
      end
   end

   // gx: bottom row minus top row; gy: newest column minus oldest column
   logic [ACC_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
   logic [GRAD_W-1:0] gx_abs, gy_abs;

   assign gx_pos = ACC_W'(win_ff[2]) + (ACC_W'(win_ff[5]) << 1) + ACC_W'(gray1_ff);
   assign gx_neg = ACC_W'(win_ff[0]) + (ACC_W'(win_ff[3]) << 1) + ACC_W'(top);
   assign gy_pos = ACC_W'(top) + (ACC_W'(mid) << 1) + ACC_W'(gray1_ff);
   assign gy_neg = ACC_W'(win_ff[0]) + (ACC_W'(win_ff[1]) << 1) + ACC_W'(win_ff[2]);

   always_comb begin
      logic [ACC_W-1:0] dx, dy;
      dx     = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
      dy     = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
      gx_abs = dx[GRAD_W-1:0];
      gy_abs = dy[GRAD_W-1:0];
   end

   logic                  evalid1;
   logic                  inner1;
   logic [COL_W-1:0]      ecol1;
   logic [ROW_W-1:0]      erow1;

   assign evalid1 = (row1_ff != '0) && (col1_ff != '0);
   assign inner1  = (row1_ff > ROW_W'(1)) && (col1_ff > COL_W'(1));
   assign ecol1   = evalid1 ? (col1_ff - COL_W'(1)) : '0;
   assign erow1   = evalid1 ? (row1_ff - ROW_W'(1)) : '0;

   logic [GRAY_W-1:0]     gray2_ff;
   logic                  evalid2_ff;
   logic                  inner2_ff;
   logic [EDGE_COL_W-1:0] ecol2_ff;
   logic [EDGE_ROW_W-1:0] erow2_ff;
   logic [GRAD_W-1:0]     gx2_ff, gy2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         gray2_ff   <= gray1_ff;
         evalid2_ff <= evalid1;
         inner2_ff  <= inner1;
         ecol2_ff   <= EDGE_COL_W'(ecol1);
         erow2_ff   <= EDGE_ROW_W'(erow1);
         gx2_ff     <= gx_abs;
         gy2_ff     <= gy_abs;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: squares
   // ------------------------------------------------------------------
   logic [GRAY_W-1:0]     gray3_ff;
   logic                  evalid3_ff;
   logic                  inner3_ff;
   logic [EDGE_COL_W-1:0] ecol3_ff;
   logic [EDGE_ROW_W-1:0] erow3_ff;
   logic [SQ_W-1:0]       gx_sq3_ff, gy_sq3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         gray3_ff   <= gray2_ff;
         evalid3_ff <= evalid2_ff;
         inner3_ff  <= inner2_ff;
         ecol3_ff   <= ecol2_ff;
         erow3_ff   <= erow2_ff;
         gx_sq3_ff  <= SQ_W'(gx2_ff) * SQ_W'(gx2_ff);
         gy_sq3_ff  <= SQ_W'(gy2_ff) * SQ_W'(gy2_ff);
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: magnitude compare into the output word
   // ------------------------------------------------------------------
   logic [LIM_SQ_W-1:0]   mag_sq;
   logic                  edge_in;
   logic [GRAY_W-1:0]     gray4_ff;
   logic                  evalid4_ff;
   logic                  edge4_ff;
   logic [EDGE_COL_W-1:0] ecol4_ff;
   logic [EDGE_ROW_W-1:0] erow4_ff;

   assign mag_sq  = LIM_SQ_W'(gx_sq3_ff) + LIM_SQ_W'(gy_sq3_ff);
   assign edge_in = inner3_ff && (mag_sq >= lim_sq_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         gray4_ff   <= gray3_ff;
         evalid4_ff <= evalid3_ff;
         edge4_ff   <= edge_in;
         ecol4_ff   <= ecol3_ff;
         erow4_ff   <= erow3_ff;
      end
   end

   assign rsp_chan.valid      = v4_ff;
   assign rsp_chan.gray       = gray4_ff;
   assign rsp_chan.edge_valid = evalid4_ff;
   assign rsp_chan.edge_res   = edge4_ff;
   assign rsp_chan.edge_row   = erow4_ff;
   assign rsp_chan.edge_col   = ecol4_ff;

`ifndef SYNTHESIS
   // Write-back and the next read always target different columns
   assert property (@(posedge clock) disable iff (reset)
      ram_we && req_fire |-> col1_ff != col_ff)
      else $error("line RAM read and write hit the same column");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.edge_valid |->
         !rsp_chan.edge_res && rsp_chan.edge_row == '0 && rsp_chan.edge_col == '0)
      else $error("edge fields set without a valid center");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.edge_res |->
         rsp_chan.edge_row != '0 && rsp_chan.edge_col != '0)
      else $error("edge flag set on a border pixel");

   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> v1_ff)
      else $error("accepted word lost from the first stage");
`endif

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sobel_edge_threshold_unit. Pixels go in through a
// queue-fed driver; every accepted pixel is run through a local gray/Sobel
// model whose expected word is then matched against the returned word.
// Frame sizes and the threshold are changed over APB between phases, with
// random input gaps, output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CHAN_W       = sobet_pkg::CHAN_W;
   localparam int GRAY_W       = sobet_pkg::GRAY_W;
   localparam int EDGE_ROW_W   = sobet_pkg::EDGE_ROW_W;
   localparam int EDGE_COL_W   = sobet_pkg::EDGE_COL_W;
   localparam int CSR_ADDR_W   = sobet_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W   = sobet_pkg::CSR_DATA_W;
   localparam int WIDTH_REG_W  = sobet_pkg::WIDTH_REG_W;
   localparam int HEIGHT_REG_W = sobet_pkg::HEIGHT_REG_W;
   localparam int THRESH_REG_W = sobet_pkg::THRESH_REG_W;
   localparam int MIN_SIZE     = sobet_pkg::MIN_SIZE;

   localparam int MAX_W         = 1024;
   localparam int MAX_H         = 4096;
   localparam int RANDOM_PIXELS = 700;
   localparam int DRAIN_CYCLES  = 8;
   localparam int LONG_HOLD     = 300;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SHOWN_ERRORS  = 10;

   // idle modes
   localparam int unsigned IDLE_NONE = 0;
   localparam int unsigned IDLE_SEND = 1;
   localparam int unsigned IDLE_RECV = 2;
   localparam int unsigned IDLE_BOTH = 3;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [GRAY_W-1:0]     gray;
      logic                  edge_valid;
      logic                  edge_res;
      logic [EDGE_ROW_W-1:0] edge_row;
      logic [EDGE_COL_W-1:0] edge_col;
   } res_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   sobet_pix_if pix_if ();
   sobet_res_if res_if ();

   sobel_edge_threshold_unit #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (pix_if),
      .rsp_chan    (res_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // model state: register copies, line store, window, counters
   logic [WIDTH_REG_W-1:0]  width_reg  = sobet_pkg::IMAGE_WIDTH_RST;
   logic [HEIGHT_REG_W-1:0] height_reg = sobet_pkg::IMAGE_HEIGHT_RST;
   logic [THRESH_REG_W-1:0] thresh_reg = sobet_pkg::EDGE_THRESHOLD_RST;
   logic [GRAY_W-1:0]       line_buf [0:1][0:MAX_W-1] = '{default: '0};
   logic [GRAY_W-1:0]       win_px [0:5] = '{default: '0};
   int unsigned             col_cnt = 0;
   int unsigned             row_cnt = 0;

   pixel_type    pixel_q [$];
   res_word_type expected_words [$];
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_stall_pct = 0;
   int unsigned  fault_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  hold_left = 0;
   logic         hold_kick = 1'b0;
   logic         hold_taken = 1'b0;
   logic [7:0]   scene_level = 8'd128;

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void sobel_predict(input pixel_type px);
      int unsigned w, h, col, row, idx, lim;
      int          gx, gy, mag2;
      int          l0, l1, l2, c0, c2, r0, r1, r2;
      logic [GRAY_W-1:0] gray, top, mid;
      res_word_type want;
      w    = clamp_dim(32'(width_reg), MAX_W);
      h    = clamp_dim(32'(height_reg), MAX_H);
      gray = GRAY_W'((int'(px.red) + int'(px.green) + int'(px.blue)) / 3);
      col  = col_cnt;
      row  = row_cnt;
      idx  = (col < MAX_W) ? col : MAX_W - 1;
      top  = line_buf[0][idx];
      mid  = line_buf[1][idx];
      want = '0;
      want.gray = gray;
      if (row >= 1 && col >= 1) begin
         want.edge_valid = 1'b1;
         want.edge_row   = EDGE_ROW_W'(row - 1);
         want.edge_col   = EDGE_COL_W'(col - 1);
         // window center on the first row or column stays flagged low
         if (row >= 2 && col >= 2) begin
            l0 = int'(win_px[0]); l1 = int'(win_px[1]); l2 = int'(win_px[2]);
            c0 = int'(win_px[3]); c2 = int'(win_px[5]);
            r0 = int'(top); r1 = int'(mid); r2 = int'(gray);
            gx   = (l2 + 2 * c2 + r2) - (l0 + 2 * c0 + r0);
            gy   = (r0 + 2 * r1 + r2) - (l0 + 2 * l1 + l2);
            mag2 = gx * gx + gy * gy;
            lim  = 32'(thresh_reg) + 1;
            want.edge_res = (mag2 >= int'(lim * lim));
         end
      end
      line_buf[0][idx] = mid;
      line_buf[1][idx] = gray;
      win_px[0] = win_px[3];
      win_px[1] = win_px[4];
      win_px[2] = win_px[5];
      win_px[3] = top;
      win_px[4] = mid;
      win_px[5] = gray;
      if (col + 1 >= w) begin
         col_cnt = 0;
         row_cnt = (row + 1 >= h) ? 0 : row + 1;
      end else begin
         col_cnt = col + 1;
      end
      expected_words.insert(expected_words.size(), want);
   endfunction

   function automatic void queue_pixel(input pixel_type px);
      pixel_q.insert(pixel_q.size(), px);
   endfunction

   function automatic pixel_type rgb(input int r, input int g, input int b);
      pixel_type px;
      px.red   = CHAN_W'(r);
      px.green = CHAN_W'(g);
      px.blue  = CHAN_W'(b);
      return px;
   endfunction

   function automatic int near_level(input int level);
      int v;
      v = level + int'($urandom_range(12)) - 6;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v;
   endfunction

   // mostly flat patches with small noise, some hard steps, some pure noise
   function automatic pixel_type random_pixel();
      int unsigned p;
      p = $urandom_range(99);
      if (p < 20) return rgb(int'($urandom_range(255)), int'($urandom_range(255)),
                             int'($urandom_range(255)));
      if (p < 35) begin
         case ($urandom_range(2))
            0: scene_level = 8'h00;
            1: scene_level = 8'hff;
            default: scene_level = 8'($urandom_range(255));
         endcase
         return rgb(int'(scene_level), int'(scene_level), int'(scene_level));
      end
      return rgb(near_level(int'(scene_level)), near_level(int'(scene_level)),
                 near_level(int'(scene_level)));
   endfunction

   function automatic int unsigned pixels_to_frame_start();
      int unsigned n, c, r, w, h;
      n = 0;
      c = col_cnt;
      r = row_cnt;
      w = clamp_dim(32'(width_reg), MAX_W);
      h = clamp_dim(32'(height_reg), MAX_H);
      while (c != 0 || r != 0) begin
         if (c + 1 >= w) begin
            c = 0;
            r = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            c = c + 1;
         end
         n = n + 1;
      end
      return n;
   endfunction

   // ---------------- pixel driver ----------------
   always @(posedge clock) begin : pix_driver
      pixel_type px;
      pixel_type seen;
      if (reset) begin
         pix_if.valid <= 1'b0;
         pix_if.red   <= '0;
         pix_if.green <= '0;
         pix_if.blue  <= '0;
      end else begin
         if (pix_if.valid && pix_if.ready) begin
            seen = {pix_if.red, pix_if.green, pix_if.blue};
            sobel_predict(seen);
         end
         if (!pix_if.valid || pix_if.ready) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               px = pixel_q.pop_front();
               pix_if.valid <= 1'b1;
               pix_if.red   <= px.red;
               pix_if.green <= px.green;
               pix_if.blue  <= px.blue;
            end else begin
               pix_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- long output hold-off ----------------
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_kick && !hold_taken) begin
         hold_left  <= LONG_HOLD;
         hold_taken <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------- result monitor ----------------
   always @(posedge clock) begin : rsp_monitor
      res_word_type got, want;
      if (reset) begin
         res_if.ready <= 1'b0;
      end else begin
         if (res_if.valid && res_if.ready) begin
            got = {res_if.gray, res_if.edge_valid, res_if.edge_res,
                   res_if.edge_row, res_if.edge_col};
            if (expected_words.size() == 0) begin
               fault_count = fault_count + 1;
               if (fault_count <= SHOWN_ERRORS)
                  $display("%0t: stray word: gray %0d ev %0d er %0d row %0d col %0d",
                           $time, got.gray, got.edge_valid, got.edge_res, got.edge_row,
                           got.edge_col);
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  fault_count = fault_count + 1;
                  if (fault_count <= SHOWN_ERRORS) begin
                     $display("%0t: mismatch want gray %0d ev %0d er %0d row %0d col %0d",
                              $time, want.gray, want.edge_valid, want.edge_res,
                              want.edge_row, want.edge_col);
                     $display("%0t: mismatch got  gray %0d ev %0d er %0d row %0d col %0d",
                              $time, got.gray, got.edge_valid, got.edge_res,
                              got.edge_row, got.edge_col);
                  end
               end
            end
         end
         res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   task automatic wait_idle();
      do @(negedge clock);
      while (pixel_q.size() != 0 || pix_if.valid || expected_words.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock);
      while (!csr_pready);
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         sobet_pkg::REG_IMAGE_WIDTH:    width_reg  = value[WIDTH_REG_W-1:0];
         sobet_pkg::REG_IMAGE_HEIGHT:   height_reg = value[HEIGHT_REG_W-1:0];
         sobet_pkg::REG_EDGE_THRESHOLD: thresh_reg = value[THRESH_REG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [WIDTH_REG_W-1:0] w, input logic [HEIGHT_REG_W-1:0] h,
                            input logic [THRESH_REG_W-1:0] t);
      if (row_cnt != 0 && clamp_dim(32'(w), MAX_W) > clamp_dim(32'(width_reg), MAX_W)) begin
         // widening past row 0 would read line columns never filled: end the frame first
         csr_write(sobet_pkg::REG_IMAGE_HEIGHT, CSR_DATA_W'(MIN_SIZE));
         @(negedge clock);
         repeat (pixels_to_frame_start()) queue_pixel(random_pixel());
         wait_idle();
      end
      csr_write(sobet_pkg::REG_IMAGE_WIDTH, CSR_DATA_W'(w));
      csr_write(sobet_pkg::REG_IMAGE_HEIGHT, CSR_DATA_W'(h));
      csr_write(sobet_pkg::REG_EDGE_THRESHOLD, CSR_DATA_W'(t));
   endtask

   task automatic set_idle(input int unsigned mode);
      case (mode)
         IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SEND: begin send_idle_pct = 45; recv_stall_pct = 0;  end
         IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 45; end
         default:   begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
   endtask

   initial begin : stimulus
      int unsigned phase, n, p, random_sent;
      logic [WIDTH_REG_W-1:0]  w;
      logic [HEIGHT_REG_W-1:0] h;
      logic [THRESH_REG_W-1:0] t;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset sizes: a few words on row 0 of a 640-wide frame, channel extremes
      @(negedge clock);
      queue_pixel(rgb(0, 0, 0));
      queue_pixel(rgb(255, 255, 255));
      queue_pixel(rgb(255, 0, 0));
      queue_pixel(rgb(0, 255, 0));
      queue_pixel(rgb(0, 0, 255));
      queue_pixel(rgb(1, 1, 0));
      wait_idle();

      // sizes below the minimum clamp to 3; column 6 is past the new width and wraps
      configure(11'd2, 13'd1, 11'd0);
      @(negedge clock);
      queue_pixel(rgb(2, 2, 1));
      for (int k = 0; k < 12; k++)
         queue_pixel((k % 3 == 0) ? rgb(0, 0, 0) : rgb(255, 255, 255));
      wait_idle();

      // same hard step, threshold above the largest Sobel magnitude: no edge
      configure(11'd3, 13'd3, 11'd1443);
      @(negedge clock);
      queue_pixel(rgb(0, 0, 0));
      queue_pixel(rgb(255, 255, 255));
      queue_pixel(rgb(254, 255, 255));
      wait_idle();

      // sizes above the maximum clamp to the widest line and tallest frame
      configure(11'd2047, 13'd8191, 11'($urandom_range(0, 400)));
      @(negedge clock);
      repeat (40) queue_pixel(random_pixel());
      wait_idle();

      phase = 0;
      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         p = $urandom_range(99);
         if (p < 10)      w = 11'($urandom_range(0, 2));
         else if (p < 90) w = 11'($urandom_range(3, 12));
         else             w = 11'($urandom_range(13, 40));
         p = $urandom_range(99);
         if (p < 15)      h = 13'($urandom_range(0, 2));
         else if (p < 75) h = 13'($urandom_range(3, 8));
         else if (p < 90) h = 13'($urandom_range(9, 64));
         else if (p < 95) h = 13'd4096;
         else             h = 13'($urandom_range(4097, 8191));
         p = $urandom_range(99);
         if (p < 60)      t = 11'($urandom_range(0, 300));
         else if (p < 90) t = 11'($urandom_range(301, 1443));
         else             t = (p < 95) ? 11'd1443 : 11'd2047;
         configure(w, h, t);
         set_idle(phase % 4);
         n = $urandom_range(20, 110);
         @(negedge clock);
         // input keeps streaming while the output is held off: the unit must fill up
         if (phase == 4) hold_kick = 1'b1;
         repeat (n) queue_pixel(random_pixel());
         random_sent = random_sent + n;
         phase = phase + 1;
         wait_idle();
      end

      set_idle(IDLE_NONE);
      repeat (20) @(posedge clock);
      if (fault_count == 0 && expected_words.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
